### rtl/dbsg_pkg.sv
// Shared types and constants of the de Bruijn sequence generator.
`default_nettype none

package dbsg_pkg;

  localparam int unsigned MAX_ORDER_DEF = 12;
  localparam int unsigned ORDER_W       = 4;
  localparam int unsigned POS_W         = 12;
  localparam int unsigned ROW_LOG_MAX   = 6;
  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_LOOK,
    ST_EXH,
    ST_TOS
  } dbsg_state_e;

  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic vis_rd;
    logic push;
    logic pop;
    logic emit_exh;
    logic tos_load;
  } dbsg_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic cnt_done;
    logic v0;
    logic v1;
    logic sp_zero;
    logic out_free;
  } dbsg_sts_t;

endpackage

`default_nettype wire

### rtl/dbsg_ctrl.sv
// Controller state machine that sequences the depth-first walk steps.
`default_nettype none

module dbsg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              restart_i,
  input  wire dbsg_pkg::dbsg_sts_t sts_i,
  output dbsg_pkg::dbsg_cmd_t    cmd_o,
  output logic                   in_ready_o
);
  import dbsg_pkg::*;

  dbsg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept_i) begin
          if (restart_i) begin
            cmd_o.clr_init = 1'b1;
            state_d        = ST_CLEAR;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_READ;
      end
      ST_READ: begin
        if (sts_i.cnt_done) begin
          state_d = ST_EXH;
        end else begin
          cmd_o.vis_rd = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // Take the first free edge out of the current node, else go back one edge.
        if (!(sts_i.v0 && sts_i.v1)) begin
          cmd_o.push = 1'b1;
          state_d    = ST_READ;
        end else if (sts_i.sp_zero) begin
          state_d = ST_EXH;
        end else if (sts_i.out_free) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_TOS;
        end
      end
      ST_EXH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_exh = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_TOS: begin
        cmd_o.tos_load = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/dbsg_dp.sv
// Datapath: order register, edge bitmap, walk stack, counters and result register.
`default_nettype none

module dbsg_dp #(
  parameter int unsigned MAX_ORDER = dbsg_pkg::MAX_ORDER_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dbsg_pkg::ORDER_W-1:0]  cfg_data_i,
  input  wire dbsg_pkg::dbsg_cmd_t           cmd_i,
  output dbsg_pkg::dbsg_sts_t                sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_digit_o,
  output logic [dbsg_pkg::POS_W-1:0]         out_position_o,
  output logic                               out_last_o,
  output logic                               out_exhausted_o
);
  import dbsg_pkg::*;

  localparam int unsigned EW       = MAX_ORDER;
  localparam int unsigned SPW      = MAX_ORDER + 1;
  localparam int unsigned NW       = $clog2(MAX_ORDER + 1);
  localparam int unsigned ROW_LOG  = (MAX_ORDER > ROW_LOG_MAX) ? ROW_LOG_MAX : MAX_ORDER;
  localparam int unsigned ROW_W    = 1 << ROW_LOG;
  localparam int unsigned ROWS_LOG = MAX_ORDER - ROW_LOG;
  localparam int unsigned ROWS     = 1 << ROWS_LOG;
  localparam int unsigned RA_W     = (ROWS_LOG > 0) ? ROWS_LOG : 1;
  localparam int unsigned DEPTH    = 1 << EW;

  logic [ORDER_W-1:0] order_q;
  logic [NW-1:0]      n_used;
  logic [SPW-1:0]     len;
  logic [EW-1:0]      edge_mask;

  logic [ROW_W-1:0]   vis_mem [ROWS];
  logic [ROW_W-1:0]   row_q;
  logic [EW-1:0]      stk_mem [DEPTH];
  logic [EW-1:0]      stk_rd_q;

  logic [RA_W-1:0]    clr_row_q;
  logic [SPW-1:0]     sp_q;
  logic [SPW-1:0]     cnt_q;
  logic [EW-1:0]      tos_q;
  logic [EW-1:0]      e0;
  logic [EW-1:0]      e0_q;
  logic [EW-1:0]      e_push;
  logic [ROW_LOG-1:0] off0;
  logic [ROW_LOG-1:0] off1;
  logic               v0;
  logic               v1;

  logic               vis_we;
  logic [RA_W-1:0]    vis_wa;
  logic [ROW_W-1:0]   vis_wd;

  logic               out_valid_q;
  logic               out_digit_q;
  logic [POS_W-1:0]   out_pos_q;
  logic               out_last_q;
  logic               out_exh_q;
  logic               out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RST;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  // The order is used saturated to 1..MAX_ORDER.
  always_comb begin
    if (order_q == '0) begin
      n_used = NW'(1);
    end else if (32'(order_q) > MAX_ORDER) begin
      n_used = NW'(MAX_ORDER);
    end else begin
      n_used = NW'(order_q);
    end
  end

  assign len       = SPW'(1) << n_used;
  assign edge_mask = EW'(len - SPW'(1));

  // Edge with digit 0 out of the node at the top of the stack; its digit 1 partner
  // is the neighbouring bit of the same bitmap row.
  assign e0     = (sp_q == '0) ? '0 : ((tos_q << 1) & edge_mask);
  assign off0   = e0_q[ROW_LOG-1:0];
  assign off1   = off0 | ROW_LOG'(1);
  assign v0     = row_q[off0];
  assign v1     = row_q[off1];
  assign e_push = v0 ? (e0_q | EW'(1)) : e0_q;

  always_comb begin
    vis_we = 1'b0;
    vis_wa = clr_row_q;
    vis_wd = '0;
    if (cmd_i.clr_step) begin
      vis_we = 1'b1;
    end else if (cmd_i.push) begin
      vis_we = 1'b1;
      vis_wa = RA_W'(e0_q >> ROW_LOG);
      vis_wd = row_q | (ROW_W'(1) << e_push[ROW_LOG-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (cmd_i.vis_rd) begin
      row_q <= vis_mem[RA_W'(e0 >> ROW_LOG)];
      e0_q  <= e0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stk_mem[sp_q[EW-1:0]] <= e_push;
    end
    if (cmd_i.pop) begin
      stk_rd_q <= stk_mem[EW'(sp_q - SPW'(2))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      tos_q <= e_push;
    end else if (cmd_i.tos_load) begin
      tos_q <= stk_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
      sp_q      <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.clr_init) begin
        clr_row_q <= '0;
        sp_q      <= '0;
        cnt_q     <= '0;
      end else begin
        if (cmd_i.clr_step) clr_row_q <= clr_row_q + RA_W'(1);
        if (cmd_i.push) sp_q <= sp_q + SPW'(1);
        if (cmd_i.pop) begin
          sp_q  <= sp_q - SPW'(1);
          cnt_q <= cnt_q + SPW'(1);
        end
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pop || cmd_i.emit_exh) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      out_digit_q <= tos_q[0];
      out_pos_q   <= POS_W'(cnt_q);
      out_last_q  <= (cnt_q + SPW'(1)) == len;
      out_exh_q   <= 1'b0;
    end else if (cmd_i.emit_exh) begin
      out_digit_q <= 1'b0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
      out_exh_q   <= 1'b1;
    end
  end

  assign sts_o.clr_done = clr_row_q == RA_W'(ROWS - 1);
  assign sts_o.cnt_done = cnt_q >= len;
  assign sts_o.v0       = v0;
  assign sts_o.v1       = v1;
  assign sts_o.sp_zero  = sp_q == '0;
  assign sts_o.out_free = out_free;

  assign out_valid_o     = out_valid_q;
  assign out_digit_o     = out_digit_q;
  assign out_position_o  = out_pos_q;
  assign out_last_o      = out_last_q;
  assign out_exhausted_o = out_exh_q;

endmodule

`default_nettype wire

### rtl/de_bruijn_sequence_generator_unit.sv
// Binary de Bruijn sequence generator: each request item returns the next digit.
//
// The input stream carries one request item per transfer: tdata bit 0 is restart.
// A restart clears the walk and returns the first digit; otherwise the next digit
// of the order-n sequence (2^n digits long) comes back. Each request gives exactly
// one result item on the output stream: tdata holds the digit and its position,
// tlast marks the final digit and tuser flags a request made after the end.
// The order register is written over the cfg channel, which is always ready.
// An item runs as push and pop steps of the depth-first walk, which are bound by
// the registered read of the edge bitmap: pushes until the current node has no
// free edge, then one pop that hands over the digit and a reload of the stack top.
// A restart first clears the edge bitmap row by row, 2^MAX_ORDER / 64 rows
// (64 rows at MAX_ORDER = 12; a single row when MAX_ORDER is below 6).
// After reset the same clearing pass runs before the first item is taken.
// The result sits in an output register; while the receiver stalls the block
// keeps working on the next request and waits only when it has a result to hand
// over.
`default_nettype none

module de_bruijn_sequence_generator_unit #(
  parameter int unsigned MAX_ORDER = dbsg_pkg::MAX_ORDER_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [0] restart, [7:1] zero
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // [0] digit, [12:1] position
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser,  // [0] exhausted
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [dbsg_pkg::ORDER_W-1:0] cfg_data_i
);
  import dbsg_pkg::*;

  dbsg_cmd_t        cmd;
  dbsg_sts_t        sts;
  logic             in_ready;
  logic             digit;
  logic [POS_W-1:0] position;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;

  dbsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (s_axis_tvalid && in_ready),
    .restart_i  (s_axis_tdata[0]),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  dbsg_dp #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_digit_o     (digit),
    .out_position_o  (position),
    .out_last_o      (m_axis_tlast),
    .out_exhausted_o (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, position, digit};

endmodule

`default_nettype wire

### rtl/dbsg_checker.sv
// Port-level checks of the de Bruijn sequence generator, bound to the top level.
`default_nettype none

module dbsg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // An item after the end carries no digit and no position.
  a_exh_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'h0000 && !m_axis_tlast)
    else $error("exhausted item carries data");

  // The final digit sits at position 2^n - 1, which is odd.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && m_axis_tdata[1])
    else $error("last item at an even position");

  // One request is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind de_bruijn_sequence_generator_unit dbsg_checker u_dbsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
